// ===== rtl/dioc_pkg.sv =====
// dioc_pkg: shared types and constants for the digram index of coincidence core
// holds the request and response payload structs and the default parameter values
// no dependencies; used by the core and its checker
package dioc_pkg;

   // default parameter values
   localparam int MAX_PAIRS_DEF = 2048;
   localparam int ALPHABET_DEF  = 26;
   localparam int FRAC_BITS_DEF = 24;

   // fixed field widths of the payloads
   localparam int SYMBOL_W = 5;
   localparam int RATIO_W  = 25;
   localparam int NUM_W    = 22;
   localparam int DEN_W    = 22;
   localparam int PAIRS_W  = 12;

   // one input transfer
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } req_type;

   // one result transfer
   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic [NUM_W-1:0]   numerator;
      logic [DEN_W-1:0]   denominator;
      logic [PAIRS_W-1:0] pair_count;
      logic               degenerate;
      logic               overflowed;
   } rsp_type;

endpackage

// ===== rtl/digram_index_of_coincidence_core.sv =====
// digram_index_of_coincidence_core: counts non-overlapping symbol pairs of a text
// in a bin memory, then walks the bins and divides to give the index of coincidence
// depends on dioc_pkg for payload types and parameter defaults
//
//   channel   ports                        handshake
//   input     start, busy, req_data        transfer when start && !busy
//   result    rsp_valid, rsp_data          one-cycle strobe, always taken
//
// one symbol per cycle while a text streams in; each pair does a read-modify-write
// of the bin memory, and a pair forms only on every second symbol so no two overlap.
// after the last symbol: a settle state, a walk of all ALPHABET*ALPHABET bins (676
// by default) through the memory read port, a drain of the walk pipeline, FRAC_BITS+1
// divider steps (25 by default), then the result strobe; busy is high over all of that.
// after reset a clearing pass over all ALPHABET*ALPHABET bins (676) holds busy high.
// the result side cannot stall; results go out for one cycle from an output register.
module digram_index_of_coincidence_core #(
   parameter int MAX_PAIRS = dioc_pkg::MAX_PAIRS_DEF,
   parameter int ALPHABET  = dioc_pkg::ALPHABET_DEF,
   parameter int FRAC_BITS = dioc_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dioc_pkg::req_type req_data,
   output logic              rsp_valid,
   output dioc_pkg::rsp_type rsp_data
);

   localparam int SW        = dioc_pkg::SYMBOL_W;
   localparam int CW        = $clog2(MAX_PAIRS + 1);
   localparam int BIN_TOTAL = ALPHABET * ALPHABET;
   localparam int AW        = $clog2(BIN_TOTAL);
   localparam int WCW       = $clog2(BIN_TOTAL + 1);
   localparam int PW        = 2 * CW;
   localparam int RW        = PW + 1;
   localparam int QW        = FRAC_BITS + 1;
   localparam int DCW       = $clog2(FRAC_BITS + 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SETTLE = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [SW-1:0]  held_symbol_ff, held_symbol_in;
   logic           holding_ff, holding_in;
   logic [CW-1:0]  pairs_ff, pairs_in;
   logic           overflow_ff, overflow_in;
   logic [WCW-1:0] walk_cnt_ff, walk_cnt_in;
   logic           pend_ff, pend_in;
   logic           walk_vld_ff, walk_vld_in;
   logic [AW-1:0]  rd_addr_d_ff;
   logic           prod_vld_ff;
   logic [PW-1:0]  prod_ff;
   logic [PW-1:0]  acc_ff, acc_in;
   logic [PW-1:0]  den_ff, den_in;
   logic [RW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]  quot_ff, quot_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   dioc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // bin memory
   logic [CW-1:0] bins_mem [BIN_TOTAL];
   logic [CW-1:0] mem_rd_data_ff;
   logic          mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   logic [CW-1:0] mem_wr_data;

   logic          accept, pair_go, walk_issue, finish;
   logic [SW-1:0] sym_clamped;
   logic [AW-1:0] pair_addr;
   logic [CW-1:0] f_minus1, n_minus1;
   logic [RW-1:0] trial;
   logic          trial_ge;
   logic [QW-1:0] quot_final;
   logic          degen;
   logic [QW+dioc_pkg::RATIO_W-1:0] ratio_wide;
   logic [PW+dioc_pkg::NUM_W-1:0]   num_wide;
   logic [PW+dioc_pkg::DEN_W-1:0]   den_wide;
   logic [CW+dioc_pkg::PAIRS_W-1:0] pairs_wide;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // symbol saturation and pair address
   always_comb begin
      accept      = start && !busy;
      sym_clamped = (req_data.symbol >= ALPHABET) ? SW'(ALPHABET - 1) : req_data.symbol;
      pair_addr   = AW'(int'(held_symbol_ff) * ALPHABET + int'(sym_clamped));
      pair_go     = accept && holding_ff && (pairs_ff < MAX_PAIRS);
      walk_issue  = (state_ff == ST_WALK) && (walk_cnt_ff < BIN_TOTAL);
   end

   // memory port selection
   always_comb begin
      mem_rd_en   = pair_go || walk_issue;
      mem_rd_addr = pair_go ? pair_addr : walk_cnt_ff[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = rd_addr_d_ff;
      mem_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = walk_cnt_ff[AW-1:0];
      end else if (pend_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_data = mem_rd_data_ff + CW'(1);
      end else if (walk_vld_ff) begin
         mem_wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         mem_rd_data_ff <= bins_mem[mem_rd_addr];
      end
      if (mem_wr_en) begin
         bins_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   // divider step: first step compares without a shift to get the integer bit
   always_comb begin
      trial      = (div_cnt_ff == '0) ? rem_ff : {rem_ff[RW-2:0], 1'b0};
      trial_ge   = (trial >= {1'b0, den_ff});
      quot_final = {quot_ff[QW-2:0], trial_ge};
      f_minus1   = (mem_rd_data_ff == '0) ? '0 : mem_rd_data_ff - CW'(1);
      n_minus1   = (pairs_ff == '0) ? '0 : pairs_ff - CW'(1);
      degen      = (pairs_ff < 2);
   end

   // result fields resized to the port widths
   always_comb begin
      ratio_wide = {{dioc_pkg::RATIO_W{1'b0}}, (degen ? {QW{1'b0}} : quot_final)};
      num_wide   = {{dioc_pkg::NUM_W{1'b0}}, acc_ff};
      den_wide   = {{dioc_pkg::DEN_W{1'b0}}, den_ff};
      pairs_wide = {{dioc_pkg::PAIRS_W{1'b0}}, pairs_ff};
      rsp_data_in.ratio       = ratio_wide[dioc_pkg::RATIO_W-1:0];
      rsp_data_in.numerator   = num_wide[dioc_pkg::NUM_W-1:0];
      rsp_data_in.denominator = den_wide[dioc_pkg::DEN_W-1:0];
      rsp_data_in.pair_count  = pairs_wide[dioc_pkg::PAIRS_W-1:0];
      rsp_data_in.degenerate  = degen;
      rsp_data_in.overflowed  = overflow_ff;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      held_symbol_in = held_symbol_ff;
      holding_in     = holding_ff;
      pairs_in       = pairs_ff;
      overflow_in    = overflow_ff;
      walk_cnt_in    = walk_cnt_ff;
      pend_in        = pair_go;
      walk_vld_in    = walk_issue;
      acc_in         = prod_vld_ff ? acc_ff + prod_ff : acc_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = 1'b0;
      finish         = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            walk_cnt_in = walk_cnt_ff + WCW'(1);
            if (walk_cnt_ff == WCW'(BIN_TOTAL - 1)) begin
               walk_cnt_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (holding_ff) begin
                  holding_in = 1'b0;
                  if (pair_go) begin
                     pairs_in = pairs_ff + CW'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  held_symbol_in = sym_clamped;
                  holding_in     = 1'b1;
               end
               if (req_data.last) begin
                  state_in = ST_SETTLE;
               end
            end
         end
         ST_SETTLE: begin
            // last pair write lands here; walk starts after it
            den_in      = {{CW{1'b0}}, pairs_ff} * {{CW{1'b0}}, n_minus1};
            acc_in      = '0;
            walk_cnt_in = '0;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            if (walk_issue) begin
               walk_cnt_in = walk_cnt_ff + WCW'(1);
            end else if (!walk_vld_ff && !prod_vld_ff) begin
               rem_in     = {1'b0, acc_ff};
               quot_in    = '0;
               div_cnt_in = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in     = trial_ge ? trial - {1'b0, den_ff} : trial;
            quot_in    = quot_final;
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(FRAC_BITS)) begin
               finish         = 1'b1;
               rsp_valid_in   = 1'b1;
               held_symbol_in = '0;
               holding_in     = 1'b0;
               pairs_in       = '0;
               overflow_in    = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         held_symbol_ff <= '0;
         holding_ff     <= 1'b0;
         pairs_ff       <= '0;
         overflow_ff    <= 1'b0;
         walk_cnt_ff    <= '0;
         pend_ff        <= 1'b0;
         walk_vld_ff    <= 1'b0;
         prod_vld_ff    <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         held_symbol_ff <= held_symbol_in;
         holding_ff     <= holding_in;
         pairs_ff       <= pairs_in;
         overflow_ff    <= overflow_in;
         walk_cnt_ff    <= walk_cnt_in;
         pend_ff        <= pend_in;
         walk_vld_ff    <= walk_vld_in;
         prod_vld_ff    <= walk_vld_ff;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_addr_d_ff <= mem_rd_addr;
      prod_ff      <= {{CW{1'b0}}, mem_rd_data_ff} * {{CW{1'b0}}, f_minus1};
      acc_ff       <= acc_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/dioc_checker.sv =====
// dioc_checker: port-level assertions for the digram index of coincidence core
// watches only the top-level ports; bound to the core at the end of this file
// depends on dioc_pkg for payload types
module dioc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input dioc_pkg::req_type req_data,
   input logic              rsp_valid,
   input dioc_pkg::rsp_type rsp_data
);

   // a final symbol always starts the evaluation
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last |=> busy)
      else $error("final symbol transfer did not raise busy");

   // one result per text, never on consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // the result comes out as the core returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // degenerate texts report a zero ratio
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.ratio == '0)
      else $error("degenerate result with nonzero ratio");

   // coincidences never exceed the pair product
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |-> rsp_data.numerator <= rsp_data.denominator)
      else $error("numerator above denominator");

endmodule

bind digram_index_of_coincidence_core dioc_checker u_dioc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
